/* rtl/core/rlkd_pkg.sv */
// ----------------------------------------------------------------------------
// rlkd_pkg
// Shared types, codes and the key window decode for the resistor ladder
// key decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlkd_pkg;

    // Key codes
    localparam logic [2:0] KEY_NONE     = 3'd0;
    localparam logic [2:0] KEY_NEXT     = 3'd1;
    localparam logic [2:0] KEY_PREV     = 3'd2;
    localparam logic [2:0] KEY_VOL_UP   = 3'd3;
    localparam logic [2:0] KEY_VOL_DOWN = 3'd4;
    localparam logic [2:0] KEY_MODE     = 3'd5;

    // Event kinds
    localparam logic [1:0] EV_RELEASE = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_HELD    = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_IDLE_THR  = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE  = 3'd1;
    localparam logic [2:0] REG_POLL_STEP = 3'd2;
    localparam logic [2:0] REG_HOLD_DLY  = 3'd3;
    localparam logic [2:0] REG_REPEAT    = 3'd4;

    // Register reset values
    localparam logic [7:0]  RST_IDLE_THR  = 8'd240;
    localparam logic [3:0]  RST_DEBOUNCE  = 4'd2;
    localparam logic [9:0]  RST_POLL_STEP = 10'd25;
    localparam logic [15:0] RST_HOLD_DLY  = 16'd1200;
    localparam logic [15:0] RST_REPEAT    = 16'd100;

    // Key window bounds on the scaled level (inclusive)
    localparam logic [7:0] WIN_NEXT_HI = 8'd11;
    localparam logic [7:0] WIN_A_LO    = 8'd43;
    localparam logic [7:0] WIN_A_HI    = 8'd65;
    localparam logic [7:0] WIN_B_LO    = 8'd98;
    localparam logic [7:0] WIN_B_HI    = 8'd120;
    localparam logic [7:0] WIN_C_LO    = 8'd162;
    localparam logic [7:0] WIN_C_HI    = 8'd184;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_OUT
    } t_state;

    // Remainder unit status
    typedef struct packed {
        logic done;
        logic zero;
    } t_mod_status;

    // Map a scaled level to a key code for one ladder channel
    function automatic logic [2:0] decode_key(input logic ch, input logic [7:0] level,
                                              input logic [7:0] thr);
        logic [2:0] key;
        key = KEY_NONE;
        if (level < thr) begin
            if (!ch) begin
                if (level <= WIN_NEXT_HI) begin
                    key = KEY_NEXT;
                end else if (level >= WIN_A_LO && level <= WIN_A_HI) begin
                    key = KEY_PREV;
                end
            end else begin
                if (level >= WIN_A_LO && level <= WIN_A_HI) begin
                    key = KEY_VOL_UP;
                end else if (level >= WIN_B_LO && level <= WIN_B_HI) begin
                    key = KEY_VOL_DOWN;
                end else if (level >= WIN_C_LO && level <= WIN_C_HI) begin
                    key = KEY_MODE;
                end
            end
        end
        return key;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rlkd_if.sv */
// ----------------------------------------------------------------------------
// rlkd_if
// Valid/ready channels: ADC sample in, key event out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rlkd_sample_if;
    logic        valid;
    logic        ready;
    logic        channel;
    logic [11:0] raw_sample;

    modport source (output valid, output channel, output raw_sample, input ready);
    modport sink   (input valid, input channel, input raw_sample, output ready);
endinterface

interface rlkd_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_id;
    logic [1:0] event_kind;

    modport source (output valid, output key_id, output event_kind, input ready);
    modport sink   (input valid, input key_id, input event_kind, output ready);
endinterface

`default_nettype wire

/* rtl/core/rlkd_mod_unit.sv */
// ----------------------------------------------------------------------------
// rlkd_mod_unit
// Bit-serial restoring remainder: 16-bit dividend mod 16-bit divisor, one
// quotient bit per cycle; reports whether the remainder is zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlkd_mod_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire [15:0]           i_dividend,
    input  wire [15:0]           i_divisor,
    output rlkd_pkg::t_mod_status o_status
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_dvd;
    logic [15:0] r_dvs;

    logic [16:0] w_trial;
    logic [16:0] w_diff;
    logic        w_fit;

    // One restoring step
    always_comb begin
        w_trial = {r_rem, r_dvd[15]};
        w_fit   = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[15:0] : w_trial[15:0];
            r_dvd <= {r_dvd[14:0], 1'b0};
        end
    end

    assign o_status.done = r_done;
    assign o_status.zero = (r_rem == 16'd0);

endmodule

`default_nettype wire

/* rtl/core/resistor_ladder_key_decoder.sv */
// ----------------------------------------------------------------------------
// resistor_ladder_key_decoder
// Decodes ladder ADC samples into debounced press, held-repeat and release
// key events for up to two channels.
// ----------------------------------------------------------------------------
// Channel     Dir  Contents                         Handshake
// i_key_in    in   channel, raw_sample              valid/ready
// o_key_ev    out  key_id, event_kind               valid/ready
// APB         in   5 config regs at 4*i, 32-bit     psel/penable, pready=1
//
// One sample at a time: the block takes it and evaluates it, then is either
// done or runs the bit-serial remainder unit for a held-repeat check; an
// event then waits in the output register until taken.
// Reset (synchronous, active low) clears all channel state and loads the
// register defaults. i_key_in.ready is low while a sample is in work or an
// event is pending. Samples for a channel beyond NUM_CHANNELS are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module resistor_ladder_key_decoder #(
    parameter int NUM_CHANNELS = 2
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    rlkd_sample_if.sink       i_key_in,
    rlkd_event_if.source      o_key_ev,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [4:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Configuration registers
    logic [7:0]  r_idle_thr;
    logic [3:0]  r_debounce;
    logic [9:0]  r_poll_step;
    logic [15:0] r_hold_dly;
    logic [15:0] r_repeat;

    // Per-channel state
    logic [2:0]  r_cand   [NUM_CHANNELS];
    logic [3:0]  r_count  [NUM_CHANNELS];
    logic [2:0]  r_active [NUM_CHANNELS];
    logic [15:0] r_hold   [NUM_CHANNELS];

    // Sample in work and pending event
    rlkd_pkg::t_state r_state, n_state;
    logic [CH_W-1:0]  r_ch;
    logic             r_ch_raw;
    logic [7:0]       r_level;
    logic [2:0]       r_ev_key;
    logic [1:0]       r_ev_kind;

    logic             w_in_take;
    logic             w_ch_ok;
    logic [2:0]       w_key;
    logic [3:0]       w_new_cnt;
    logic             w_accept;
    logic             w_press;
    logic             w_release;
    logic             w_hold_upd;
    logic [15:0]      w_hold_sum;
    logic             w_start_div;
    logic [15:0]      w_past;
    logic             w_cfg_wr;
    rlkd_pkg::t_mod_status w_mod;

    // APB access
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_thr  <= rlkd_pkg::RST_IDLE_THR;
            r_debounce  <= rlkd_pkg::RST_DEBOUNCE;
            r_poll_step <= rlkd_pkg::RST_POLL_STEP;
            r_hold_dly  <= rlkd_pkg::RST_HOLD_DLY;
            r_repeat    <= rlkd_pkg::RST_REPEAT;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                rlkd_pkg::REG_IDLE_THR:  r_idle_thr  <= pwdata[7:0];
                rlkd_pkg::REG_DEBOUNCE:  r_debounce  <= pwdata[3:0];
                rlkd_pkg::REG_POLL_STEP: r_poll_step <= pwdata[9:0];
                rlkd_pkg::REG_HOLD_DLY:  r_hold_dly  <= pwdata[15:0];
                rlkd_pkg::REG_REPEAT:    r_repeat    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            rlkd_pkg::REG_IDLE_THR:  prdata = {24'd0, r_idle_thr};
            rlkd_pkg::REG_DEBOUNCE:  prdata = {28'd0, r_debounce};
            rlkd_pkg::REG_POLL_STEP: prdata = {22'd0, r_poll_step};
            rlkd_pkg::REG_HOLD_DLY:  prdata = {16'd0, r_hold_dly};
            rlkd_pkg::REG_REPEAT:    prdata = {16'd0, r_repeat};
            default:                 prdata = 32'd0;
        endcase
    end

    // Input side
    assign i_key_in.ready = (r_state == rlkd_pkg::S_IDLE);
    assign w_in_take      = i_key_in.valid && i_key_in.ready;
    assign w_ch_ok        = (32'(i_key_in.channel) < NUM_CHANNELS);

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_ch     <= CH_W'(i_key_in.channel);
            r_ch_raw <= i_key_in.channel;
            r_level  <= i_key_in.raw_sample[11:4];
        end
    end

    // Decode, debounce and event decision for the sample in work
    always_comb begin
        w_key = rlkd_pkg::decode_key(r_ch_raw, r_level, r_idle_thr);
        if (w_key == r_cand[r_ch]) begin
            w_new_cnt = (r_count[r_ch] < r_debounce) ? r_count[r_ch] + 4'd1 : r_count[r_ch];
        end else begin
            w_new_cnt = 4'd1;
        end
        w_accept   = (w_new_cnt >= r_debounce);
        w_hold_sum = r_hold[r_ch] + 16'(r_poll_step);
        w_past     = w_hold_sum - r_hold_dly;
        w_press    = w_accept && (w_key != rlkd_pkg::KEY_NONE)
                     && (r_active[r_ch] == rlkd_pkg::KEY_NONE);
        w_hold_upd = w_accept && (w_key != rlkd_pkg::KEY_NONE)
                     && (r_active[r_ch] == w_key);
        w_release  = w_accept && (w_key == rlkd_pkg::KEY_NONE)
                     && (r_active[r_ch] != rlkd_pkg::KEY_NONE);
        w_start_div = (r_state == rlkd_pkg::S_EVAL) && w_hold_upd
                      && (w_hold_sum >= r_hold_dly) && (r_repeat != 16'd0);
    end

    // Shared remainder unit for the repeat check
    rlkd_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start_div),
        .i_dividend (w_past),
        .i_divisor  (r_repeat),
        .o_status   (w_mod)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlkd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rlkd_pkg::S_IDLE: begin
                if (w_in_take && w_ch_ok) n_state = rlkd_pkg::S_EVAL;
            end
            rlkd_pkg::S_EVAL: begin
                if (w_press || w_release) begin
                    n_state = rlkd_pkg::S_OUT;
                end else if (w_start_div) begin
                    n_state = rlkd_pkg::S_DIV;
                end else begin
                    n_state = rlkd_pkg::S_IDLE;
                end
            end
            rlkd_pkg::S_DIV: begin
                if (w_mod.done) n_state = w_mod.zero ? rlkd_pkg::S_OUT : rlkd_pkg::S_IDLE;
            end
            rlkd_pkg::S_OUT: begin
                if (o_key_ev.ready) n_state = rlkd_pkg::S_IDLE;
            end
            default: n_state = rlkd_pkg::S_IDLE;
        endcase
    end

    // Channel state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_cand[i]   <= rlkd_pkg::KEY_NONE;
                r_count[i]  <= 4'd0;
                r_active[i] <= rlkd_pkg::KEY_NONE;
                r_hold[i]   <= 16'd0;
            end
        end else if (r_state == rlkd_pkg::S_EVAL) begin
            r_cand[r_ch]  <= w_key;
            r_count[r_ch] <= w_new_cnt;
            if (w_press) begin
                r_active[r_ch] <= w_key;
                r_hold[r_ch]   <= 16'd0;
            end else if (w_hold_upd) begin
                r_hold[r_ch] <= w_hold_sum;
            end else if (w_release) begin
                r_active[r_ch] <= rlkd_pkg::KEY_NONE;
                r_hold[r_ch]   <= 16'd0;
            end
        end
    end

    // Event register
    always_ff @(posedge i_clk) begin
        if (r_state == rlkd_pkg::S_EVAL) begin
            if (w_release) begin
                r_ev_key  <= r_active[r_ch];
                r_ev_kind <= rlkd_pkg::EV_RELEASE;
            end else begin
                r_ev_key  <= w_key;
                r_ev_kind <= w_press ? rlkd_pkg::EV_PRESS : rlkd_pkg::EV_HELD;
            end
        end
    end

    assign o_key_ev.valid      = (r_state == rlkd_pkg::S_OUT);
    assign o_key_ev.key_id     = r_ev_key;
    assign o_key_ev.event_kind = r_ev_kind;

    // Checks
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod.done |-> r_state == rlkd_pkg::S_DIV)
        else $error("remainder done outside repeat check");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key_ev.valid |-> (o_key_ev.key_id != rlkd_pkg::KEY_NONE)
                           && (o_key_ev.key_id <= rlkd_pkg::KEY_MODE))
        else $error("event with invalid key code");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_key_in.ready |-> !o_key_ev.valid)
        else $error("sample taken while event pending");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start_div |=> r_state == rlkd_pkg::S_DIV)
        else $error("repeat check started without entering wait state");

endmodule

`default_nettype wire

/* tb/resistor_ladder_key_decoder_tb.sv */
// ----------------------------------------------------------------------------
// resistor_ladder_key_decoder_tb
// Self-checking bench for the ladder key decoder. A short table of directed
// samples and register writes comes first, then phases of random key runs
// under varied register settings. A local predictor tracks debounce, press,
// held-repeat and release per channel. Each event transaction is checked
// against the oldest pending prediction. Sender gaps are off or random and
// receiver stalls off, random or a fixed pattern, by phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module resistor_ladder_key_decoder_tb;

    localparam int NUM_DIR_ROWS = 30;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 116;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_ERR_LINES = 40;

    typedef struct packed {
        logic [2:0] key_id;
        logic [1:0] event_kind;
    } t_key_event;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;
    // How a directed row is checked: typed no-event, typed event, or predictor
    typedef enum logic [1:0] {CHK_QUIET, CHK_EVENT, CHK_MODEL} t_row_check;
    typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PATTERN} t_stall_mode;

    typedef struct packed {
        t_row_kind   kind;
        logic        ch;
        logic [11:0] raw;
        t_row_check  check;
        logic [2:0]  key;
        logic [1:0]  ev;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rlkd_sample_if key_in();
    rlkd_event_if  key_ev();

    resistor_ladder_key_decoder uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key_in (key_in),
        .o_key_ev (key_ev),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor copy of the registers
    logic [7:0]  cfg_idle_thr   = rlkd_pkg::RST_IDLE_THR;
    logic [3:0]  cfg_debounce   = rlkd_pkg::RST_DEBOUNCE;
    logic [9:0]  cfg_poll_step  = rlkd_pkg::RST_POLL_STEP;
    logic [15:0] cfg_hold_delay = rlkd_pkg::RST_HOLD_DLY;
    logic [15:0] cfg_repeat     = rlkd_pkg::RST_REPEAT;

    // Predictor copy of the per-channel state
    logic [2:0]  cand_key   [2];
    logic [3:0]  stable_cnt [2];
    logic [2:0]  act_key    [2];
    logic [15:0] hold_ms    [2];

    t_key_event  pending_events[$];
    int          error_count;
    int          events_seen;
    int          cycle_count = 0;
    int          burst_left;
    bit          gaps_on;
    t_stall_mode stall_mode;
    t_dir_row    dir_rows [NUM_DIR_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        if (error_count < MAX_ERR_LINES) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // Debounce, press, held-repeat and release tracking for one sample
    function automatic bit predict_key_event(input logic ch, input logic [11:0] raw,
                                             output t_key_event ev);
        logic [7:0]  level;
        logic [2:0]  key;
        logic [15:0] past;
        level = raw[11:4];
        ev    = '0;
        key   = rlkd_pkg::KEY_NONE;
        if (level < cfg_idle_thr) begin
            if (!ch) begin
                if (level <= 8'd11) begin
                    key = rlkd_pkg::KEY_NEXT;
                end else if (level >= 8'd43 && level <= 8'd65) begin
                    key = rlkd_pkg::KEY_PREV;
                end
            end else begin
                if (level >= 8'd43 && level <= 8'd65) begin
                    key = rlkd_pkg::KEY_VOL_UP;
                end else if (level >= 8'd98 && level <= 8'd120) begin
                    key = rlkd_pkg::KEY_VOL_DOWN;
                end else if (level >= 8'd162 && level <= 8'd184) begin
                    key = rlkd_pkg::KEY_MODE;
                end
            end
        end

        if (key == cand_key[ch]) begin
            if (stable_cnt[ch] < cfg_debounce) stable_cnt[ch] = stable_cnt[ch] + 4'd1;
        end else begin
            cand_key[ch]   = key;
            stable_cnt[ch] = 4'd1;
        end
        if (stable_cnt[ch] < cfg_debounce) return 1'b0;

        if (key != rlkd_pkg::KEY_NONE) begin
            if (act_key[ch] == rlkd_pkg::KEY_NONE) begin
                act_key[ch] = key;
                hold_ms[ch] = '0;
                ev = '{key_id: key, event_kind: rlkd_pkg::EV_PRESS};
                return 1'b1;
            end
            // same key still down: advance hold timer, repeat on interval
            if (act_key[ch] == key) begin
                hold_ms[ch] = hold_ms[ch] + {6'b0, cfg_poll_step};
                if (hold_ms[ch] >= cfg_hold_delay && cfg_repeat != 16'd0) begin
                    past = hold_ms[ch] - cfg_hold_delay;
                    if (past % cfg_repeat == 16'd0) begin
                        ev = '{key_id: key, event_kind: rlkd_pkg::EV_HELD};
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        end

        if (act_key[ch] != rlkd_pkg::KEY_NONE) begin
            ev = '{key_id: act_key[ch], event_kind: rlkd_pkg::EV_RELEASE};
            act_key[ch] = rlkd_pkg::KEY_NONE;
            hold_ms[ch] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Random raw sample whose scaled level falls in the window of a key, or in no window for KEY_NONE
    function automatic logic [11:0] raw_for_key(input logic [2:0] key);
        logic [7:0] level;
        case (key) inside
            rlkd_pkg::KEY_NEXT:     level = 8'($urandom_range(0, 11));
            rlkd_pkg::KEY_PREV,
            rlkd_pkg::KEY_VOL_UP:   level = 8'($urandom_range(43, 65));
            rlkd_pkg::KEY_VOL_DOWN: level = 8'($urandom_range(98, 120));
            rlkd_pkg::KEY_MODE:     level = 8'($urandom_range(162, 184));
            default:                level = $urandom_range(0, 1) ? 8'd255
                                                                 : 8'($urandom_range(12, 42));
        endcase
        return {level, 4'($urandom)};
    endfunction

    // Send one sample transaction, record the expectation, then maybe gap
    task automatic drive_sample(input logic ch, input logic [11:0] raw,
                                input t_row_check check, input logic [2:0] key,
                                input logic [1:0] ev);
        t_key_event pred;
        bit         hit;
        key_in.valid      <= 1'b1;
        key_in.channel    <= ch;
        key_in.raw_sample <= raw;
        do @(posedge i_clk); while (!key_in.ready);
        hit = predict_key_event(ch, raw, pred);
        if (check == CHK_EVENT) begin
            pending_events.push_back('{key_id: key, event_kind: ev});
        end else if (check == CHK_MODEL && hit) begin
            pending_events.push_back(pred);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = gaps_on ? $urandom_range(0, 11) : 1000;
            if (gaps_on) begin
                key_in.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending and let the block finish everything in flight
    task automatic drain_events();
        key_in.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
        logic [15:0] stored;
        case (idx)
            rlkd_pkg::REG_IDLE_THR:  stored = {8'b0, value[7:0]};
            rlkd_pkg::REG_DEBOUNCE:  stored = {12'b0, value[3:0]};
            rlkd_pkg::REG_POLL_STEP: stored = {6'b0, value[9:0]};
            default:                 stored = value;
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            rlkd_pkg::REG_IDLE_THR:  cfg_idle_thr   = stored[7:0];
            rlkd_pkg::REG_DEBOUNCE:  cfg_debounce   = stored[3:0];
            rlkd_pkg::REG_POLL_STEP: cfg_poll_step  = stored[9:0];
            rlkd_pkg::REG_HOLD_DLY:  cfg_hold_delay = stored;
            rlkd_pkg::REG_REPEAT:    cfg_repeat     = stored;
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== {16'b0, stored}) begin
            flag_error($sformatf("reg %0d read back %0h, wrote %0h", idx, prdata, stored));
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Event monitor and receiver stall pattern
    always @(posedge i_clk) begin : event_monitor
        t_key_event want;
        if (i_rst_n && key_ev.valid && key_ev.ready) begin
            events_seen++;
            if (pending_events.size() == 0) begin
                flag_error($sformatf("event %0d unexpected: key %0d kind %0d", events_seen,
                                     key_ev.key_id, key_ev.event_kind));
            end else begin
                want = pending_events.pop_front();
                if (key_ev.key_id !== want.key_id) begin
                    flag_error($sformatf("event %0d key_id %0d, want %0d", events_seen,
                                         key_ev.key_id, want.key_id));
                end
                if (key_ev.event_kind !== want.event_kind) begin
                    flag_error($sformatf("event %0d event_kind %0d, want %0d", events_seen,
                                         key_ev.event_kind, want.event_kind));
                end
            end
        end
        case (stall_mode)
            STALL_NONE:   key_ev.ready <= 1'b1;
            STALL_RANDOM: key_ev.ready <= ($urandom_range(0, 3) != 0);
            default:      key_ev.ready <= ((cycle_count % 11) < 6);
        endcase
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events pending", cycle_count,
                     pending_events.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin : main_seq
        int          row_i;
        int          phase;
        int          item;
        int          seq_left;
        logic        seq_ch;
        logic [2:0]  seq_key;
        logic        ch;
        logic [11:0] raw;
        t_dir_row    row;
        logic [7:0]  thr;
        logic [3:0]  deb;
        logic [9:0]  step;
        logic [15:0] dly;
        logic [15:0] rep;

        error_count = 0;
        events_seen = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        stall_mode  = STALL_RANDOM;
        seq_left    = 0;
        seq_ch      = 1'b0;
        seq_key     = rlkd_pkg::KEY_NONE;
        for (row_i = 0; row_i < 2; row_i++) begin
            cand_key[row_i]   = rlkd_pkg::KEY_NONE;
            stable_cnt[row_i] = '0;
            act_key[row_i]    = rlkd_pkg::KEY_NONE;
            hold_ms[row_i]    = '0;
        end

        dir_rows = '{
            // press and release of next at the bottom extreme and full scale
            '{ROW_SAMPLE, 1'b0, 12'h000, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b0, 12'h000, CHK_EVENT, rlkd_pkg::KEY_NEXT,
              rlkd_pkg::EV_PRESS, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b0, 12'hFFF, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b0, 12'hFFF, CHK_EVENT, rlkd_pkg::KEY_NEXT,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            // window edges on both channels
            '{ROW_SAMPLE, 1'b1, 12'h2B0, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b1, 12'h41F, CHK_EVENT, rlkd_pkg::KEY_VOL_UP,
              rlkd_pkg::EV_PRESS, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b0, 12'h0BF, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b0, 12'h0B0, CHK_EVENT, rlkd_pkg::KEY_NEXT,
              rlkd_pkg::EV_PRESS, rlkd_pkg::REG_IDLE_THR, 16'd0},
            // other key accepted while one is active: no event
            '{ROW_SAMPLE, 1'b1, 12'h620, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b1, 12'h78F, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b1, 12'h0C0, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b1, 12'h0C0, CHK_EVENT, rlkd_pkg::KEY_VOL_UP,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b1, 12'hA20, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b1, 12'hB8F, CHK_EVENT, rlkd_pkg::KEY_MODE,
              rlkd_pkg::EV_PRESS, rlkd_pkg::REG_IDLE_THR, 16'd0},
            // every held sample lands on a repeat
            '{ROW_WRITE, 1'b0, 12'h000, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_POLL_STEP, 16'd1000},
            '{ROW_WRITE, 1'b0, 12'h000, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_HOLD_DLY, 16'd0},
            '{ROW_WRITE, 1'b0, 12'h000, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_REPEAT, 16'd1000},
            '{ROW_SAMPLE, 1'b1, 12'hB80, CHK_MODEL, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b1, 12'hAAA, CHK_MODEL, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            // zero repeat interval disables held events
            '{ROW_WRITE, 1'b0, 12'h000, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_REPEAT, 16'd0},
            '{ROW_SAMPLE, 1'b1, 12'hB8F, CHK_MODEL, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            // zero debounce accepts every sample at once
            '{ROW_WRITE, 1'b0, 12'h000, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_DEBOUNCE, 16'd0},
            '{ROW_SAMPLE, 1'b1, 12'h555, CHK_EVENT, rlkd_pkg::KEY_MODE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            // threshold zero: every level reads as no key
            '{ROW_WRITE, 1'b0, 12'h000, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b0, 12'h000, CHK_EVENT, rlkd_pkg::KEY_NEXT,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            // top threshold and longest debounce
            '{ROW_WRITE, 1'b0, 12'h000, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd255},
            '{ROW_WRITE, 1'b0, 12'h000, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_DEBOUNCE, 16'd15},
            '{ROW_SAMPLE, 1'b0, 12'hFFE, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b0, 12'h555, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0},
            '{ROW_SAMPLE, 1'b1, 12'hAAA, CHK_QUIET, rlkd_pkg::KEY_NONE,
              rlkd_pkg::EV_RELEASE, rlkd_pkg::REG_IDLE_THR, 16'd0}
        };

        i_rst_n           <= 1'b0;
        key_in.valid      <= 1'b0;
        key_in.channel    <= 1'b0;
        key_in.raw_sample <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (row_i = 0; row_i < NUM_DIR_ROWS; row_i++) begin
            row = dir_rows[row_i];
            if (row.kind == ROW_WRITE) begin
                drain_events();
                write_register(row.reg_idx, row.reg_val);
            end else begin
                drive_sample(row.ch, row.raw, row.check, row.key, row.ev);
            end
        end

        // Random phases, each under its own register setting
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain_events();
            case (phase)
                0: begin
                    thr = rlkd_pkg::RST_IDLE_THR;  deb = rlkd_pkg::RST_DEBOUNCE;
                    step = rlkd_pkg::RST_POLL_STEP;
                    dly = rlkd_pkg::RST_HOLD_DLY;  rep = rlkd_pkg::RST_REPEAT;
                end
                1: begin
                    thr = 8'd255; deb = 4'd1; step = 10'd1; dly = 16'd0; rep = 16'd1;
                end
                2: begin
                    thr = 8'($urandom_range(185, 255)); deb = 4'd15; step = 10'd1000;
                    dly = 16'd65535; rep = 16'd65535;
                end
                3: begin
                    thr = 8'd100; deb = 4'd0; step = 10'($urandom_range(1, 1000));
                    dly = 16'd0; rep = 16'd0;
                end
                default: begin
                    thr  = 8'($urandom_range(170, 255));
                    deb  = 4'($urandom_range(1, 4));
                    step = 10'($urandom_range(1, 40));
                    rep  = 16'(step * $urandom_range(1, 6));
                    dly  = 16'(step * $urandom_range(0, 10));
                end
            endcase
            write_register(rlkd_pkg::REG_IDLE_THR, {8'b0, thr});
            write_register(rlkd_pkg::REG_DEBOUNCE, {12'b0, deb});
            write_register(rlkd_pkg::REG_POLL_STEP, {6'b0, step});
            write_register(rlkd_pkg::REG_HOLD_DLY, dly);
            write_register(rlkd_pkg::REG_REPEAT, rep);

            gaps_on    = (phase % 3 != 0);
            stall_mode = t_stall_mode'(phase % 3);
            burst_left = 0;
            seq_left   = 0;

            for (item = 0; item < PHASE_ITEMS; item++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise sample, may break a run on its channel
                    ch  = 1'($urandom_range(0, 1));
                    raw = 12'($urandom_range(0, 4095));
                end else begin
                    if (seq_left == 0) begin
                        seq_ch = 1'($urandom_range(0, 1));
                        if (seq_ch) begin
                            case ($urandom_range(0, 3))
                                0:       seq_key = rlkd_pkg::KEY_NONE;
                                1:       seq_key = rlkd_pkg::KEY_VOL_UP;
                                2:       seq_key = rlkd_pkg::KEY_VOL_DOWN;
                                default: seq_key = rlkd_pkg::KEY_MODE;
                            endcase
                        end else begin
                            case ($urandom_range(0, 2))
                                0:       seq_key = rlkd_pkg::KEY_NONE;
                                1:       seq_key = rlkd_pkg::KEY_NEXT;
                                default: seq_key = rlkd_pkg::KEY_PREV;
                            endcase
                        end
                        seq_left = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 80)
                                                               : $urandom_range(1, 12);
                    end
                    seq_left--;
                    ch  = seq_ch;
                    raw = raw_for_key(seq_key);
                end
                drive_sample(ch, raw, CHK_MODEL, rlkd_pkg::KEY_NONE, rlkd_pkg::EV_RELEASE);
            end
        end

        drain_events();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
